// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that sleeps while reset is asserted.
`define DQB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define DQB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/dqb_pkg.sv =====
`timescale 1ns / 1ps
package dqb_pkg;

    localparam int MAX_LABEL = 63;
    localparam int CNT_W     = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int IDX_W     = (CNT_W > 4) ? CNT_W : 4;

    localparam int FQ_DEPTH  = 2;
    localparam int FQ_AW     = $clog2(FQ_DEPTH);

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    localparam logic [3:0] HDR_LAST  = 4'd11;
    localparam logic [2:0] TAIL_LAST = 3'd4;

    // command kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DOT  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // configuration register indexes
    localparam logic REG_QUERY_ID   = 1'b0;
    localparam logic REG_QUERY_TYPE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] name_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic       second_valid;
        logic       run_last;
        logic       packet_last;
        logic       label_overflow;
    } t_out;

    typedef struct packed {
        logic       hdr;
        logic [1:0] kind;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic [7:0] cbyte;
        logic       from_ram;
        logic       last;
        logic       pkt_end;
        logic       ovf;
    } t_desc;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
        logic [7:0] b;
        case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = 8'h01;
            4'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [2:0] idx, input logic [15:0] qtype);
        logic [7:0] b;
        case (idx)
            3'd0:    b = TERM_BYTE;
            3'd1:    b = qtype[15:8];
            3'd2:    b = qtype[7:0];
            3'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/dqb_ram.sv =====
`timescale 1ns / 1ps
module dqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== src/dqb_fifo.sv =====
`timescale 1ns / 1ps
module dqb_fifo import dqb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_empty
);

    t_cmd             r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp;
    logic [FQ_AW-1:0] r_rp;
    logic [FQ_AW:0]   r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == (FQ_AW + 1)'(FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + FQ_AW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + FQ_AW'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + (FQ_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (FQ_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/dqb_front.sv =====
`timescale 1ns / 1ps
module dqb_front import dqb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_ready,
    output logic o_wr,
    output t_cmd o_cmd,
    input  logic i_full
);

    logic r_hdr_sent;
    logic accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_wr       = accept;

    always_comb begin
        o_cmd.hdr = !r_hdr_sent;
        o_cmd.ch  = i_in_data.name_byte;
        if (i_in_data.mode) begin
            o_cmd.kind = KIND_END;
        end else if (i_in_data.name_byte == DOT_CHAR) begin
            o_cmd.kind = KIND_DOT;
        end else begin
            o_cmd.kind = KIND_CHAR;
        end
    end

    // the word after an end marker opens a new packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_sent <= 1'b0;
        end else if (accept) begin
            r_hdr_sent <= !i_in_data.mode;
        end
    end

endmodule

// ===== src/dqb_back.sv =====
`timescale 1ns / 1ps
module dqb_back import dqb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  logic [15:0] i_query_id,
    input  logic [15:0] i_query_type,
    output t_desc       o_desc,
    output logic        o_desc_valid,
    input  logic        i_desc_ready,
    output t_ram_req    o_ram
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_LBL  = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_ovf,   n_ovf;

    logic             do_store;
    logic             is_dot;
    logic [IDX_W-1:0] idx_next;
    logic             lbl_end;

    assign is_dot   = (i_cmd.kind == KIND_DOT);
    assign idx_next = r_idx + IDX_W'(1);
    assign lbl_end  = (idx_next == IDX_W'(r_cnt));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        do_store     = 1'b0;
        o_cmd_pop    = 1'b0;
        o_desc_valid = 1'b0;
        o_desc       = '{cbyte: 8'h00, from_ram: 1'b0, last: 1'b0,
                         pkt_end: (i_cmd.kind == KIND_END), ovf: r_ovf};
        o_ram        = '{we: 1'b0, waddr: r_cnt[ADDR_W-1:0], wdata: i_cmd.ch,
                         re: 1'b0, raddr: r_idx[ADDR_W-1:0]};

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.hdr) begin
                        n_ovf   = 1'b0;
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = S_HDR;
                    end else if (i_cmd.kind == KIND_CHAR) begin
                        do_store  = 1'b1;
                        o_cmd_pop = 1'b1;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_HDR: begin
                o_desc_valid = 1'b1;
                o_desc.cbyte = hdr_byte(r_idx[3:0], i_query_id);
                o_desc.last  = (r_idx[3:0] == HDR_LAST) && (i_cmd.kind == KIND_CHAR);
                if (i_desc_ready) begin
                    if (r_idx[3:0] == HDR_LAST) begin
                        if (i_cmd.kind == KIND_CHAR) begin
                            do_store  = 1'b1;
                            o_cmd_pop = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_LEN;
                        end
                    end else begin
                        n_idx = idx_next;
                    end
                end
            end
            S_LEN: begin
                o_desc_valid = 1'b1;
                o_desc.cbyte = 8'(r_cnt);
                o_desc.last  = is_dot && (r_cnt == '0);
                if (i_desc_ready) begin
                    n_idx = '0;
                    if (r_cnt != '0) begin
                        n_state = S_LBL;
                    end else if (is_dot) begin
                        o_cmd_pop = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_LBL: begin
                o_desc_valid    = 1'b1;
                o_desc.from_ram = 1'b1;
                o_desc.last     = is_dot && lbl_end;
                o_ram.re        = i_desc_ready;
                if (i_desc_ready) begin
                    if (lbl_end) begin
                        n_cnt = '0;
                        n_idx = '0;
                        if (is_dot) begin
                            o_cmd_pop = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end else begin
                        n_idx = idx_next;
                    end
                end
            end
            S_TAIL: begin
                o_desc_valid = 1'b1;
                o_desc.cbyte = tail_byte(r_idx[2:0], i_query_type);
                o_desc.last  = (r_idx[2:0] == TAIL_LAST);
                if (i_desc_ready) begin
                    if (r_idx[2:0] == TAIL_LAST) begin
                        o_cmd_pop = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_idx = idx_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // store a label character, or drop it and flag the overflow
        if (do_store) begin
            if (r_cnt < CNT_W'(MAX_LABEL)) begin
                o_ram.we = 1'b1;
                n_cnt    = r_cnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== src/dqb_pack.sv =====
`timescale 1ns / 1ps
module dqb_pack import dqb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    input  logic       i_desc_valid,
    output logic       o_desc_ready,
    input  logic [7:0] i_ram_q,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    logic       r_b_valid;
    t_desc      r_b;
    logic       r_have_first;
    logic [7:0] r_first;
    logic       r_out_valid;
    t_out       r_out;

    logic [7:0] cur_byte;
    logic       need_emit;
    logic       out_free;
    logic       b_take;
    t_out       n_out;

    assign cur_byte     = r_b.from_ram ? i_ram_q : r_b.cbyte;
    assign need_emit    = r_have_first || r_b.last;
    assign out_free     = !r_out_valid || i_out_ready;
    assign b_take       = r_b_valid && (!need_emit || out_free);
    assign o_desc_ready = !r_b_valid || b_take;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    always_comb begin
        n_out.run_last       = r_b.last;
        n_out.packet_last    = r_b.last && r_b.pkt_end;
        n_out.label_overflow = r_b.ovf;
        if (r_have_first) begin
            n_out.byte_first   = r_first;
            n_out.byte_second  = cur_byte;
            n_out.second_valid = 1'b1;
        end else begin
            n_out.byte_first   = cur_byte;
            n_out.byte_second  = 8'h00;
            n_out.second_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_ready && i_desc_valid) begin
            r_b <= i_desc;
        end
        if (b_take && !need_emit) begin
            r_first <= cur_byte;
        end
        if (b_take && need_emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_have_first <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_desc_ready) begin
                r_b_valid <= i_desc_valid;
            end
            if (b_take) begin
                r_have_first <= !need_emit;
            end
            if (b_take && need_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/dns_query_packet_builder.sv =====
`timescale 1ns / 1ps
// DNS query packet builder.
// Input channel (i_in_valid / o_in_ready, i_in_data): one host name character
// per word, or an end marker (mode = 1). Output channel (o_out_valid /
// i_out_ready, o_out_data): packet bytes two per word, with run_last on the
// last word caused by an input word and packet_last on the last word of a packet.
// Config port (i_cfg_we, i_cfg_idx, i_cfg_data) sets query id and query type;
// write it only while the block is idle.
// Throughput: a word that emits packet bytes holds the back end while they go out,
// one byte per cycle while the packer accepts, set by the single read port of the
// label store. A two-entry command queue lets the front keep accepting while the
// back end flushes.
// Reset clears the queue, the header and overflow flags and the label count;
// query id resets to 0 and query type to 1. A stalled receiver holds the
// output word; the back end then stops and the queue fills, dropping o_in_ready.
module dns_query_packet_builder import dqb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_query_id;
    logic [15:0] r_query_type;

    logic     fq_wr;
    t_cmd     fq_wdata;
    logic     fq_full;
    logic     fq_pop;
    t_cmd     fq_head;
    logic     fq_empty;
    t_desc    desc;
    logic     desc_valid;
    logic     desc_ready;
    t_ram_req ram_req;
    logic [7:0] ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id   <= 16'h0000;
            r_query_type <= 16'h0001;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUERY_ID:   r_query_id   <= i_cfg_data;
                REG_QUERY_TYPE: r_query_type <= i_cfg_data;
                default:        r_query_id   <= r_query_id;
            endcase
        end
    end

    dqb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_wr       (fq_wr),
        .o_cmd      (fq_wdata),
        .i_full     (fq_full)
    );

    dqb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_wdata (fq_wdata),
        .o_full  (fq_full),
        .i_rd    (fq_pop),
        .o_rdata (fq_head),
        .o_empty (fq_empty)
    );

    dqb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (fq_head),
        .i_cmd_valid  (!fq_empty),
        .o_cmd_pop    (fq_pop),
        .i_query_id   (r_query_id),
        .i_query_type (r_query_type),
        .o_desc       (desc),
        .o_desc_valid (desc_valid),
        .i_desc_ready (desc_ready),
        .o_ram        (ram_req)
    );

    dqb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL),
        .AW    (ADDR_W)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_q)
    );

    dqb_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (desc),
        .i_desc_valid (desc_valid),
        .o_desc_ready (desc_ready),
        .i_ram_q      (ram_q),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== src/dqb_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dqb_checker import dqb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    `DQB_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "output word changed while stalled")
    `DQB_ASSERT(a_pkt_run, i_clk, i_rst_n, o_out_valid && o_out_data.packet_last |-> o_out_data.run_last, "packet_last without run_last")
    `DQB_ASSERT(a_odd_tail, i_clk, i_rst_n, o_out_valid && !o_out_data.second_valid |-> o_out_data.run_last && (o_out_data.byte_second == 8'h00), "single byte word not at end of run")
    `DQB_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "bad state after reset")

endmodule

bind dns_query_packet_builder dqb_checker u_dqb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== dv/tb_dns_query_packet_builder.sv =====
`timescale 1ns / 1ps
module tb_dns_query_packet_builder;
    import dqb_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RANDOM_ITEMS   = 24;
    localparam int RANDOM_PHASES  = 3;
    localparam int PRESSURE_PHASE = 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SCRIPT_ROWS    = 18;

    // one directed row: word, repeat count, and an optional typed first output word
    typedef struct packed {
        t_in        word;
        logic [7:0] reps;
        logic       typed;
        t_out       first_out;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    // packet encoder shadow state
    logic [7:0]  label_bytes [MAX_LABEL];
    int unsigned label_len;
    bit          header_out;
    bit          overflow_flag;
    logic [15:0] query_id_q;
    logic [15:0] query_type_q;
    t_out        words_due [$];

    t_row        script [SCRIPT_ROWS];
    int          phase_no    = -1;
    int          error_total = 0;
    int unsigned in_steady   = 0;
    int unsigned idle_cycles = 0;

    dns_query_packet_builder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Expected output words for one accepted input word.
    function automatic void encode_step(input t_in w);
        logic [7:0]  stream [$];
        int unsigned n_words;
        t_out        o;
        if (!header_out) begin
            overflow_flag = 1'b0;
            label_len     = 0;
            stream.push_back(query_id_q[15:8]);
            stream.push_back(query_id_q[7:0]);
            stream.push_back(8'h01);
            // flags low byte, then qdcount = 1, then three zero counts
            for (int i = 0; i < 9; i++) stream.push_back((i == 2) ? 8'h01 : 8'h00);
            header_out = 1'b1;
        end
        if (w.mode || w.name_byte == DOT_CHAR) begin
            stream.push_back(8'(label_len));
            for (int i = 0; i < label_len; i++) stream.push_back(label_bytes[i]);
            label_len = 0;
        end else if (label_len < MAX_LABEL) begin
            label_bytes[label_len] = w.name_byte;
            label_len++;
        end else begin
            overflow_flag = 1'b1;
        end
        if (w.mode) begin
            stream.push_back(TERM_BYTE);
            stream.push_back(query_type_q[15:8]);
            stream.push_back(query_type_q[7:0]);
            stream.push_back(8'h00);
            stream.push_back(8'h01);
            header_out = 1'b0;
        end
        n_words = (stream.size() + 1) / 2;
        for (int k = 0; k < n_words; k++) begin
            o.byte_first     = stream[2 * k];
            o.second_valid   = (2 * k + 1 < stream.size());
            o.byte_second    = o.second_valid ? stream[2 * k + 1] : 8'h00;
            o.run_last       = (k + 1 == n_words);
            o.packet_last    = w.mode && (k + 1 == n_words);
            o.label_overflow = overflow_flag;
            words_due.push_back(o);
        end
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            error_total++;
        end
    endfunction

    task automatic send_word(input t_in w, input bit typed, input t_out first_out);
        int unsigned gap;
        int unsigned base;
        if (in_steady != 0) begin
            gap = 0;
            in_steady--;
        end else if ($urandom_range(0, 29) == 0) begin
            gap       = 0;
            in_steady = $urandom_range(15, 50);
        end else begin
            gap = pick_gap();
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        base = words_due.size();
        encode_step(w);
        if (typed && words_due.size() > base) words_due[base] = first_out;
    endtask

    task automatic send_random_name(inout int unsigned sent);
        int unsigned n_labels;
        int unsigned len;
        int unsigned roll;
        bit          noisy;
        t_in         w;
        n_labels = $urandom_range(0, 4);
        noisy    = ($urandom_range(0, 7) == 0);
        for (int l = 0; l < n_labels; l++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) len = $urandom_range(60, 68);
            else if (roll < 10) len = 0;
            else len = $urandom_range(1, 10);
            for (int c = 0; c < len; c++) begin
                w.mode      = 1'b0;
                w.name_byte = 8'($urandom_range(0, 255));
                if (noisy && $urandom_range(0, 3) == 0) w.name_byte = DOT_CHAR;
                else if (!noisy && w.name_byte == DOT_CHAR) w.name_byte = 8'h2D;
                send_word(w, 1'b0, '0);
                sent++;
            end
            if (l + 1 < n_labels || $urandom_range(0, 9) == 0) begin
                w = {1'b0, DOT_CHAR};
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
        w.mode      = 1'b1;
        w.name_byte = 8'($urandom_range(0, 255));
        send_word(w, 1'b0, '0);
        sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_QUERY_ID) query_id_q = val;
        else query_type_q = val;
    endtask

    // drop valid, drain every expected word, then let the back end go quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned sent;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_QUERY_ID;
        i_cfg_data    = '0;
        label_len     = 0;
        header_out    = 1'b0;
        overflow_flag = 1'b0;
        query_id_q    = 16'h0000;
        query_type_q  = 16'h0001;

        // mode, byte, reps, typed, first word {b1, b2, second_valid, run_last, pkt_last, ovf}
        script = '{
            {1'b0, 8'h61, 8'd1,  1'b1, 8'h00, 8'h00, 4'b1000},  // header goes out first
            {1'b0, DOT_CHAR, 8'd1, 1'b1, 8'h01, 8'h61, 4'b1100},
            {1'b0, DOT_CHAR, 8'd1, 1'b1, 8'h00, 8'h00, 4'b0100},  // two dots: empty label
            {1'b0, 8'h00, 8'd1,  1'b0, 20'h0},                  // zero is a plain character
            {1'b0, 8'hFF, 8'd1,  1'b0, 20'h0},
            {1'b1, DOT_CHAR, 8'd1, 1'b1, 8'h02, 8'h00, 4'b1000},
            {1'b1, 8'h00, 8'd1,  1'b1, 8'h00, 8'h00, 4'b1000},  // empty name
            {1'b0, DOT_CHAR, 8'd1, 1'b1, 8'h00, 8'h00, 4'b1000},  // leading dot
            {1'b0, 8'h62, 8'd63, 1'b0, 20'h0},                  // label at the limit
            {1'b1, 8'hFF, 8'd1,  1'b1, 8'h3F, 8'h62, 4'b1000},
            {1'b0, 8'h55, 8'd1,  1'b1, 8'h00, 8'h00, 4'b1000},
            {1'b0, 8'hAA, 8'd64, 1'b0, 20'h0},                  // runs past the limit
            {1'b0, DOT_CHAR, 8'd1, 1'b1, 8'h3F, 8'h55, 4'b1001},
            {1'b0, 8'h63, 8'd1,  1'b0, 20'h0},
            {1'b1, 8'h00, 8'd1,  1'b1, 8'h01, 8'h63, 4'b1001},  // overflow holds to the end
            {1'b0, 8'h64, 8'd1,  1'b1, 8'h00, 8'h00, 4'b1000},  // new header clears it
            {1'b0, DOT_CHAR, 8'd1, 1'b1, 8'h01, 8'h64, 4'b1100},
            {1'b1, 8'h00, 8'd1,  1'b1, 8'h00, 8'h00, 4'b1000}   // dot right before end
        };

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            for (int n = 0; n < script[r].reps; n++)
                send_word(script[r].word, script[r].typed && n == 0, script[r].first_out);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(REG_QUERY_ID, 16'hFFFF);
                    write_reg(REG_QUERY_TYPE, 16'hFFFF);
                end
                1: begin
                    write_reg(REG_QUERY_ID, 16'h0000);
                    write_reg(REG_QUERY_TYPE, 16'h0000);
                end
                default: begin
                    write_reg(REG_QUERY_ID, 16'($urandom_range(0, 65535)));
                    write_reg(REG_QUERY_TYPE, 16'($urandom_range(0, 65535)));
                end
            endcase
            phase_no = p;
            sent     = 0;
            while (sent < RANDOM_ITEMS / RANDOM_PHASES) send_random_name(sent);
        end

        settle();
        if (error_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : out_side
        int unsigned stall;
        int unsigned steady;
        bit          held;
        i_out_ready = 1'b0;
        stall       = 0;
        steady      = 0;
        held        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_no == PRESSURE_PHASE && !held) begin
                // hold off long enough for the command queue to back up
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (stall != 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (steady != 0) steady--;
                else if ($urandom_range(0, 19) == 0) steady = $urandom_range(20, 60);
                else stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (words_due.size() == 0) begin
                $error("unexpected output word %h", o_out_data);
                error_total++;
            end else begin
                want = words_due.pop_front();
                check_field("byte_first", want.byte_first, o_out_data.byte_first);
                check_field("byte_second", want.byte_second, o_out_data.byte_second);
                check_field("second_valid", 8'(want.second_valid),
                            8'(o_out_data.second_valid));
                check_field("run_last", 8'(want.run_last), 8'(o_out_data.run_last));
                check_field("packet_last", 8'(want.packet_last),
                            8'(o_out_data.packet_last));
                check_field("label_overflow", 8'(want.label_overflow),
                            8'(o_out_data.label_overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
